[sv/udp_arp_pkg.sv]
// ----------------------------------------------------------------------------
// udp_arp_pkg
// Shared types and protocol constants for the UDP/ARP frame builder
// ----------------------------------------------------------------------------
package udp_arp_pkg;

  localparam int HdrLen     = 42;
  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = 48;
  localparam int InDataW    = 32;
  localparam int HdrIdxW    = 6;

  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_PAYLOAD = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_UDP     = 2'd0,
    KIND_ARP_REQ = 2'd1,
    KIND_ARP_REP = 2'd2
  } kind_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_DEST_MAC      = 3'd0,
    REG_SOURCE_MAC    = 3'd1,
    REG_DEST_IP       = 3'd2,
    REG_SOURCE_IP     = 3'd3,
    REG_DEST_PORT     = 3'd4,
    REG_SOURCE_PORT   = 3'd5,
    REG_MAX_FRAME_LEN = 3'd6
  } cfg_reg_t;

  localparam logic [15:0] SOURCE_PORT_RST   = 16'd12345;
  localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd9000;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TTL        = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [15:0] IP_UDP_HDR    = 16'd28;
  localparam logic [15:0] UDP_HDR       = 16'd8;
  localparam logic [15:0] ARP_HTYPE     = 16'h0001;
  localparam logic [15:0] ARP_PTYPE     = 16'h0800;
  localparam logic [7:0]  ARP_HLEN      = 8'h06;
  localparam logic [7:0]  ARP_PLEN      = 8'h04;
  localparam logic [15:0] ARP_OP_REQ    = 16'h0001;
  localparam logic [15:0] ARP_OP_REP    = 16'h0002;
  localparam logic [47:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;

endpackage

[sv/udp_arp_frame_builder.sv]
// ----------------------------------------------------------------------------
// udp_arp_frame_builder
// Builds UDP/IPv4 and ARP Ethernet frames as a byte stream from start beats
// and payload beats.
// Payload and oversize start beats pass the input and then the output register;
// header bytes pass the input register, the header state and the output register.
// Unless the output stalls, payload beats go out 1 per cycle and a start beat that
// builds a frame sends its 42 header bytes at one per cycle, holding later beats.
// Reset: synchronous rst clears both stream registers, the frame state and
// loads the register defaults.
// ----------------------------------------------------------------------------
module udp_arp_frame_builder
  import udp_arp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // frame_kind[1:0], byte_count[17:2], payload_byte[25:18]
  input  logic                s_tuser,   // func
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // frame_byte[7:0]
  output logic                m_tlast,
  output logic                m_tuser    // too_long
);

  logic [47:0] dest_mac, source_mac;
  logic [31:0] dest_ip, source_ip;
  logic [15:0] dest_port, source_port, max_frame_len;

  logic        in_valid;
  logic        in_func;
  logic [25:0] in_data;
  logic [1:0]  in_kind;
  logic [15:0] in_plen;
  logic [7:0]  in_byte;

  logic               hdr_active;
  logic [HdrIdxW-1:0] hdr_idx;
  logic [1:0]         kind_q;
  logic [15:0]        plen_q;
  logic [18:0]        ck_sum;
  logic               in_payload;
  logic [15:0]        bytes_remaining;

  logic        out_ready, consume, is_start, kind_ok, too_long;
  logic        start_go, err_fire, hdr_fire, pay_fire, hdr_last;
  logic [15:0] eff_plen, ip_len, udp_len, ip_ck, arp_op;
  logic [16:0] f1;
  logic [15:0] f2;
  logic [47:0] arp_dst, arp_tha;
  logic [8*HdrLen-1:0] udp_hdr, arp_hdr, hdr_vec;
  logic [HdrIdxW-1:0]  sel;
  logic [7:0]          hdr_byte;

  assign in_kind = in_data[1:0];
  assign in_plen = in_data[17:2];
  assign in_byte = in_data[25:18];

  assign out_ready = !m_tvalid || m_tready;
  assign consume   = in_valid && !hdr_active && out_ready;
  assign s_tready  = !in_valid || consume;

  assign is_start = (in_func == FUNC_START);
  assign kind_ok  = (in_kind == KIND_UDP) || (in_kind == KIND_ARP_REQ)
                    || (in_kind == KIND_ARP_REP);
  assign eff_plen = (in_kind == KIND_UDP) ? in_plen : 16'd0;
  assign too_long = ({1'b0, eff_plen} + 17'(HdrLen)) > {1'b0, max_frame_len};

  assign start_go = consume && is_start && kind_ok;
  assign err_fire = start_go && too_long;
  assign hdr_fire = hdr_active && out_ready;
  assign pay_fire = consume && !is_start && in_payload;

  // header fields
  assign ip_len  = plen_q + IP_UDP_HDR;
  assign udp_len = plen_q + UDP_HDR;
  assign f1      = {1'b0, ck_sum[15:0]} + {14'd0, ck_sum[18:16]};
  assign f2      = f1[15:0] + {15'd0, f1[16]};
  assign ip_ck   = ~f2;

  assign arp_dst = (kind_q == KIND_ARP_REQ) ? BCAST_MAC : dest_mac;
  assign arp_tha = (kind_q == KIND_ARP_REP) ? dest_mac : 48'd0;
  assign arp_op  = (kind_q == KIND_ARP_REQ) ? ARP_OP_REQ : ARP_OP_REP;

  assign udp_hdr = {dest_mac, source_mac, ETH_TYPE_IPV4, IP_VER_IHL, 8'h00, ip_len,
                    16'h0000, 16'h0000, IP_TTL, IP_PROTO_UDP, ip_ck, source_ip,
                    dest_ip, source_port, dest_port, udp_len, 16'h0000};
  assign arp_hdr = {arp_dst, source_mac, ETH_TYPE_ARP, ARP_HTYPE, ARP_PTYPE, ARP_HLEN,
                    ARP_PLEN, arp_op, source_mac, source_ip, arp_tha, dest_ip};

  assign hdr_vec  = (kind_q == KIND_UDP) ? udp_hdr : arp_hdr;
  assign sel      = HdrIdxW'(HdrLen - 1) - hdr_idx;
  assign hdr_byte = hdr_vec[{sel, 3'b000} +: 8];
  assign hdr_last = (hdr_idx == HdrIdxW'(HdrLen - 1))
                    && ((kind_q != KIND_UDP) || (plen_q == 16'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_mac        <= '0;
      source_mac      <= '0;
      dest_ip         <= '0;
      source_ip       <= '0;
      dest_port       <= '0;
      source_port     <= SOURCE_PORT_RST;
      max_frame_len   <= MAX_FRAME_LEN_RST;
      in_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
      hdr_active      <= 1'b0;
      hdr_idx         <= '0;
      in_payload      <= 1'b0;
      bytes_remaining <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_DEST_MAC:      dest_mac      <= cfg_wdata;
          REG_SOURCE_MAC:    source_mac    <= cfg_wdata;
          REG_DEST_IP:       dest_ip       <= cfg_wdata[31:0];
          REG_SOURCE_IP:     source_ip     <= cfg_wdata[31:0];
          REG_DEST_PORT:     dest_port     <= cfg_wdata[15:0];
          REG_SOURCE_PORT:   source_port   <= cfg_wdata[15:0];
          REG_MAX_FRAME_LEN: max_frame_len <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (consume) begin
        in_valid <= 1'b0;
      end

      if (hdr_fire || err_fire || pay_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (hdr_fire) begin
        hdr_idx  <= hdr_idx + 1'b1;
        if (hdr_idx == HdrIdxW'(HdrLen - 1)) begin
          hdr_active <= 1'b0;
          if (kind_q == KIND_UDP && plen_q != 16'd0) begin
            in_payload      <= 1'b1;
            bytes_remaining <= plen_q;
          end
        end
      end

      if (consume && is_start) begin
        in_payload      <= 1'b0;
        bytes_remaining <= '0;
        if (kind_ok && !too_long) begin
          hdr_active <= 1'b1;
          hdr_idx    <= '0;
        end
      end

      if (pay_fire) begin
        bytes_remaining <= bytes_remaining - 16'd1;
        if (bytes_remaining == 16'd1) begin
          in_payload <= 1'b0;
        end
      end
    end
  end

  // data path, no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser;
      in_data <= s_tdata[25:0];
    end

    if (start_go && !too_long) begin
      kind_q <= in_kind;
      plen_q <= eff_plen;
    end

    // checksum partial sum, ready long before the checksum bytes go out
    if (hdr_active && hdr_idx == '0) begin
      ck_sum <= 19'({IP_VER_IHL, 8'h00}) + 19'(ip_len) + 19'({IP_TTL, IP_PROTO_UDP})
                + 19'(source_ip[31:16]) + 19'(source_ip[15:0])
                + 19'(dest_ip[31:16]) + 19'(dest_ip[15:0]);
    end

    if (hdr_fire) begin
      m_tdata <= hdr_byte;
      m_tlast <= hdr_last;
      m_tuser <= 1'b0;
    end else if (err_fire) begin
      m_tdata <= 8'h00;
      m_tlast <= 1'b1;
      m_tuser <= 1'b1;
    end else if (pay_fire) begin
      m_tdata <= in_byte;
      m_tlast <= (bytes_remaining == 16'd1);
      m_tuser <= 1'b0;
    end
  end

endmodule

[sv/udp_arp_chk.sv]
// ----------------------------------------------------------------------------
// udp_arp_chk
// Port-level checks for the UDP/ARP frame builder
// ----------------------------------------------------------------------------
module udp_arp_chk
  import udp_arp_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cfg_we,
  input logic [CfgAddrW-1:0] cfg_addr,
  input logic [CfgDataW-1:0] cfg_wdata,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [InDataW-1:0]  s_tdata,
  input logic                s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [7:0]          m_tdata,
  input logic                m_tlast,
  input logic                m_tuser
);

  // error beat is a lone zero byte that closes the frame
  a_err_beat: assert property (@(posedge clk)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
    else $error("error beat without tlast or with nonzero data");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // nothing leaves right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input register frees up right after reset
  a_rst_ready: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind udp_arp_frame_builder udp_arp_chk u_chk (.*);

[tb/tb_udp_arp_frame_builder.sv]
// ----------------------------------------------------------------------------
// tb_udp_arp_frame_builder
// Self-checking testbench for the UDP/ARP frame builder. A queue-fed driver
// sends start and payload beats, a predictor builds every expected frame byte
// from its own copy of the registers and frame state, and a monitor checks
// each output beat in order. Directed frames cover field extremes, both ARP
// kinds, oversize frames, empty payloads, aborted frames, unknown kinds and
// stray payload; random traffic then runs under several register settings
// and stall patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_udp_arp_frame_builder;
  import udp_arp_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef struct {
    func_t       func;
    logic [1:0]  kind;
    logic [15:0] plen;
    logic [7:0]  pbyte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       last;
    logic       too_long;
  } frame_beat_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;
  logic                m_tlast;
  logic                m_tuser;

  udp_arp_frame_builder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // register copies and frame state of the predictor
  logic [47:0] cfg_dest_mac, cfg_source_mac;
  logic [31:0] cfg_dest_ip, cfg_source_ip;
  logic [15:0] cfg_dest_port, cfg_source_port, cfg_max_len;
  logic [15:0] payload_left;
  bit          in_frame;
  logic [7:0]  hdr_bytes [HdrLen];

  in_beat_t    tx_items[$];
  frame_beat_t exp_frame[$];
  in_beat_t    cur_item;
  bit          offering;

  int send_idle_pct, recv_idle_pct;
  int hold_token, hold_seen, hold_left;
  int errors, beats_in, beats_out, items_made, settings_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void put_be(int at, logic [47:0] v, int n);
    for (int k = 0; k < n; k++) hdr_bytes[at+k] = 8'(v >> (8 * (n - 1 - k)));
  endfunction

  function automatic void build_expected_frame(in_beat_t b);
    logic [15:0] plen;
    logic [31:0] sum;
    bit          last_hdr;
    if (b.func == FUNC_PAYLOAD) begin
      if (!in_frame) return;
      payload_left = payload_left - 16'd1;
      if (payload_left == 0) in_frame = 0;
      exp_frame.push_back('{fbyte: b.pbyte, last: (payload_left == 0), too_long: 1'b0});
      return;
    end
    in_frame = 0;
    payload_left = 0;
    if (b.kind == KIND_UNKNOWN) return;
    plen = (b.kind == KIND_UDP) ? b.plen : 16'd0;
    if (HdrLen + plen > cfg_max_len) begin
      exp_frame.push_back('{fbyte: 8'd0, last: 1'b1, too_long: 1'b1});
      return;
    end
    for (int i = 0; i < HdrLen; i++) hdr_bytes[i] = 8'd0;
    if (b.kind == KIND_UDP) begin
      put_be(0, cfg_dest_mac, 6);
      put_be(6, cfg_source_mac, 6);
      put_be(12, ETH_TYPE_IPV4, 2);
      hdr_bytes[14] = IP_VER_IHL;
      put_be(16, IP_UDP_HDR + plen, 2);
      hdr_bytes[22] = IP_TTL;
      hdr_bytes[23] = IP_PROTO_UDP;
      put_be(26, cfg_source_ip, 4);
      put_be(30, cfg_dest_ip, 4);
      sum = 0;
      for (int i = 14; i < 34; i += 2) sum += {hdr_bytes[i], hdr_bytes[i+1]};
      while (sum >> 16) sum = (sum & 32'hFFFF) + (sum >> 16);
      put_be(24, ~sum[15:0], 2);
      put_be(34, cfg_source_port, 2);
      put_be(36, cfg_dest_port, 2);
      put_be(38, UDP_HDR + plen, 2);
      last_hdr = (plen == 0);
    end else begin
      put_be(0, (b.kind == KIND_ARP_REQ) ? BCAST_MAC : cfg_dest_mac, 6);
      put_be(6, cfg_source_mac, 6);
      put_be(12, ETH_TYPE_ARP, 2);
      put_be(14, ARP_HTYPE, 2);
      put_be(16, ARP_PTYPE, 2);
      hdr_bytes[18] = ARP_HLEN;
      hdr_bytes[19] = ARP_PLEN;
      put_be(20, (b.kind == KIND_ARP_REQ) ? ARP_OP_REQ : ARP_OP_REP, 2);
      put_be(22, cfg_source_mac, 6);
      put_be(28, cfg_source_ip, 4);
      if (b.kind == KIND_ARP_REP) put_be(32, cfg_dest_mac, 6);
      put_be(38, cfg_dest_ip, 4);
      last_hdr = 1;
    end
    for (int i = 0; i < HdrLen; i++)
      exp_frame.push_back('{fbyte: hdr_bytes[i], last: (i == HdrLen - 1) && last_hdr,
                            too_long: 1'b0});
    if (!last_hdr) begin
      in_frame = 1;
      payload_left = plen;
    end
  endfunction

  // input side: feed queued beats, predict on every accepted beat
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      offering = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        build_expected_frame(cur_item);
        beats_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = tx_items.pop_front();
          offering = 1;
          s_tvalid <= 1'b1;
          s_tdata  <= {{(InDataW-26){1'b0}}, cur_item.pbyte, cur_item.plen, cur_item.kind};
          s_tuser  <= cur_item.func;
        end else begin
          offering = 0;
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= 500;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    frame_beat_t exp;
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (exp_frame.size() == 0) begin
        $error("unexpected beat: byte %0h last %0b too_long %0b", m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        exp = exp_frame.pop_front();
        if (m_tdata !== exp.fbyte) begin
          $error("frame_byte: expected %0h, got %0h", exp.fbyte, m_tdata);
          errors++;
        end
        if (m_tlast !== exp.last) begin
          $error("frame_last: expected %0b, got %0b", exp.last, m_tlast);
          errors++;
        end
        if (m_tuser !== exp.too_long) begin
          $error("too_long: expected %0b, got %0b", exp.too_long, m_tuser);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [47:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    case (r)
      REG_DEST_MAC:      cfg_dest_mac    = v;
      REG_SOURCE_MAC:    cfg_source_mac  = v;
      REG_DEST_IP:       cfg_dest_ip     = v[31:0];
      REG_SOURCE_IP:     cfg_source_ip   = v[31:0];
      REG_DEST_PORT:     cfg_dest_port   = v[15:0];
      REG_SOURCE_PORT:   cfg_source_port = v[15:0];
      REG_MAX_FRAME_LEN: cfg_max_len     = v[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [47:0] dmac, logic [47:0] smac, logic [31:0] dip,
                            logic [31:0] sip, logic [15:0] dport, logic [15:0] sport,
                            logic [15:0] max_len);
    write_reg(REG_DEST_MAC, dmac);
    write_reg(REG_SOURCE_MAC, smac);
    write_reg(REG_DEST_IP, dip);
    write_reg(REG_SOURCE_IP, sip);
    write_reg(REG_DEST_PORT, dport);
    write_reg(REG_SOURCE_PORT, sport);
    write_reg(REG_MAX_FRAME_LEN, max_len);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  task automatic set_random_config(logic [15:0] max_len);
    set_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom, $urandom,
               16'($urandom), 16'($urandom), max_len);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (tx_items.size() != 0 || offering || exp_frame.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_start(logic [1:0] kind, logic [15:0] plen);
    tx_items.push_back('{func: FUNC_START, kind: kind, plen: plen, pbyte: 8'($urandom)});
    items_made++;
  endtask

  task automatic send_payload(logic [7:0] b);
    tx_items.push_back('{func: FUNC_PAYLOAD, kind: 2'($urandom), plen: 16'($urandom),
                         pbyte: b});
    items_made++;
  endtask

  task automatic send_frame(logic [1:0] kind, logic [15:0] plen);
    send_start(kind, plen);
    if (kind == KIND_UDP && HdrLen + plen <= cfg_max_len)
      repeat (plen) send_payload(8'($urandom));
  endtask

  task automatic random_traffic(int n_items);
    int          target, pick, room;
    logic [15:0] plen;
    target = items_made + n_items;
    while (items_made < target) begin
      pick = $urandom_range(99);
      room = int'(cfg_max_len) - HdrLen;
      if (pick < 55) begin
        pick = $urandom_range(99);
        if (pick < 10) plen = 16'($urandom) | 16'h8000;
        else if (pick < 25 && room >= 0 && room <= 40) plen = 16'(room);
        else if (pick < 35 && room >= -1) plen = 16'(room + 1);
        else plen = 16'($urandom_range(0, (room < 0) ? 0 : ((room > 12) ? 12 : room)));
        send_frame(KIND_UDP, plen);
      end else if (pick < 70) begin
        send_frame((pick < 63) ? KIND_ARP_REQ : KIND_ARP_REP, 16'($urandom));
      end else if (pick < 85) begin
        // frame cut short by the next start
        plen = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
        send_start(KIND_UDP, plen);
        repeat ($urandom_range(0, (plen > 16'd4) ? 4 :
                                  ((plen == 16'd0) ? 0 : int'(plen) - 1)))
          send_payload(8'($urandom));
      end else if (pick < 92) begin
        send_payload(8'($urandom));
      end else begin
        send_start(KIND_UNKNOWN, 16'($urandom));
      end
    end
    send_start(KIND_UNKNOWN, 16'($urandom));
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    m_tready      = 1'b0;
    cfg_dest_mac    = '0;
    cfg_source_mac  = '0;
    cfg_dest_ip     = '0;
    cfg_source_ip   = '0;
    cfg_dest_port   = '0;
    cfg_source_port = SOURCE_PORT_RST;
    cfg_max_len     = MAX_FRAME_LEN_RST;
    payload_left  = '0;
    in_frame      = 0;
    send_idle_pct = 37;
    recv_idle_pct = 61;
    hold_token    = 0;
    errors        = 0;
    beats_in      = 0;
    beats_out     = 0;
    items_made    = 0;
    settings_done = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register defaults straight out of reset
    send_frame(KIND_UDP, 16'd1);
    send_frame(KIND_ARP_REQ, 16'd0);
    wait_idle();

    // all-ones addresses and ports, largest frame limit
    set_config('1, '1, '1, '1, '1, '1, 16'hFFFF);
    send_frame(KIND_UDP, 16'd0);
    send_start(KIND_UDP, 16'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h5A);
    send_frame(KIND_ARP_REQ, 16'd0);
    send_frame(KIND_ARP_REP, 16'd0);
    send_start(KIND_UNKNOWN, 16'd0);
    send_payload(8'hFF);
    send_start(KIND_UDP, 16'hFFFF);
    send_start(KIND_UDP, 16'(16'hFFFF - HdrLen));
    send_payload(8'h00);
    send_start(KIND_ARP_REP, 16'hFFFF);
    send_start(KIND_UDP, 16'd2);
    send_payload(8'hC3);
    send_start(KIND_UNKNOWN, 16'hFFFF);
    send_payload(8'h3C);
    wait_idle();

    // all zeros, every frame oversize
    set_config('0, '0, '0, '0, '0, '0, 16'd0);
    send_frame(KIND_UDP, 16'd0);
    send_frame(KIND_ARP_REQ, 16'd0);
    send_frame(KIND_ARP_REP, 16'd0);
    send_frame(KIND_UDP, 16'hFFFF);
    wait_idle();

    set_random_config(16'($urandom_range(41, 90)));
    random_traffic(60);
    wait_idle();

    send_idle_pct = 61;
    recv_idle_pct = 37;
    set_random_config(16'($urandom_range(60, 2000)));
    hold_token++;
    random_traffic(60);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_random_config(16'($urandom_range(42, 100)));
    random_traffic(30);
    wait_idle();
    random_traffic(30);
    wait_idle();

    $display("Run covered %0d input beats and %0d output beats under %0d register settings",
             beats_in, beats_out, settings_done);
    $display("with UDP and ARP frames, oversize, aborted, unknown-kind and stray beats");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
